[design/npvs_pkg.sv]
`timescale 1ns / 1ps

package npvs_pkg;

	localparam int MAX_DIM    = 64;
	localparam int COMPONENTS = 1;
	localparam int IW         = $clog2(MAX_DIM);
	localparam int AW         = 3 * IW;
	localparam int PW         = 24;
	localparam int SW         = 7;
	localparam int CIW        = 3;
	localparam int DW         = 64;

	localparam logic [CIW-1:0] CFG_SIZE_X = 3'd0;
	localparam logic [CIW-1:0] CFG_SIZE_Y = 3'd1;
	localparam logic [CIW-1:0] CFG_SIZE_Z = 3'd2;
	localparam logic [CIW-1:0] CFG_RES_X  = 3'd3;
	localparam logic [CIW-1:0] CFG_RES_Y  = 3'd4;
	localparam logic [CIW-1:0] CFG_RES_Z  = 3'd5;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                  action;
		logic [IW-1:0]         write_x;
		logic [IW-1:0]         write_y;
		logic [IW-1:0]         write_z;
		logic [COMPONENTS-1:0] positive_mask;
		logic [PW-1:0]         pos_x;
		logic [PW-1:0]         pos_y;
		logic [PW-1:0]         pos_z;
	} item_t;

	typedef struct packed {
		logic [IW-1:0] found_x;
		logic [IW-1:0] found_y;
		logic [IW-1:0] found_z;
		logic          center_positive;
		logic          not_found;
	} result_t;

	// size 0 acts as 1, sizes above the grid act as the grid
	function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = s;
		if (s == '0)
			r = SW'(1);
		else if (s > SW'(MAX_DIM))
			r = SW'(MAX_DIM);
		return r;
	endfunction

endpackage

[design/nearest_positive_voxel_search_core.sv]
`timescale 1ns / 1ps
// Write beat: written to the flag store when taken, no result.
// Query: the shared divider locates each axis in turn, then the center flag is read;
// if it is clear, each window voxel has its flag read and a positive one goes through
// the distance pipeline, for every component, and then the result is loaded.
// Reset: config returns to defaults and a clearing pass writes all MAX_DIM^3 = 262144
// flag entries to zero, with item_stall high until it ends.
module nearest_positive_voxel_search_core #(
	parameter int RADIUS = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  npvs_pkg::item_t          item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output npvs_pkg::result_t        result,
	input  logic                     cfg_we,
	input  logic [npvs_pkg::CIW-1:0] cfg_index,
	input  logic [npvs_pkg::PW-1:0]  cfg_data
);

	import npvs_pkg::*;

	localparam logic [SW-1:0] RAD  = SW'(RADIUS);
	localparam logic [SW-1:0] SPAN = SW'(2 * RADIUS);
	localparam int CMW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_DIV   = 9'b000000100,
		ST_CREQ  = 9'b000001000,
		ST_CCHK  = 9'b000010000,
		ST_SREQ  = 9'b000100000,
		ST_SCHK  = 9'b001000000,
		ST_DIST  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [SW-1:0] size_x_q, size_y_q, size_z_q;
	logic [PW-1:0] res_x_q, res_y_q, res_z_q;
	logic [PW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [IW-1:0] cx_q, cy_q, cz_q;
	logic [IW-1:0] x_q, y_q, z_q;
	logic [IW-1:0] bx_q, by_q, bz_q;
	logic [CMW-1:0] comp_q;
	logic [1:0]    axis_q;
	logic [AW-1:0] clr_q;
	logic [DW-1:0] best_q;
	logic          have_q;
	logic          cpos_q;
	logic          div_go_q;
	logic          dist_go_q;
	logic          result_valid_q;
	result_t       result_q;

	logic [SW-1:0] sx, sy, sz;
	logic [SW-1:0] x0, x1, y0, y1, z0, z1;
	logic [SW-1:0] sel_size;
	logic [PW-1:0] div_num, div_den, div_quo;
	logic          div_done;
	logic [IW-1:0] clamped;
	logic          dist_done;
	logic [DW-1:0] dist_sq;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [COMPONENTS-1:0] ram_wdata, ram_rdata;

	logic [IW-1:0]  x_n, y_n, z_n;
	logic [CMW-1:0] comp_n;
	logic           scan_last;
	logic           take_item;
	logic           out_load;

	assign sx = eff_size(size_x_q);
	assign sy = eff_size(size_y_q);
	assign sz = eff_size(size_z_q);

	function automatic logic [SW-1:0] win_lo(input logic [IW-1:0] c);
		return ({1'b0, c} < RAD) ? '0 : SW'({1'b0, c} - RAD);
	endfunction

	function automatic logic [SW-1:0] win_hi(input logic [SW-1:0] lo, input logic [SW-1:0] s);
		logic [SW-1:0] e;
		e = lo + SPAN;
		return (e > s) ? s : e;
	endfunction

	assign x0 = win_lo(cx_q);
	assign y0 = win_lo(cy_q);
	assign z0 = win_lo(cz_q);
	assign x1 = win_hi(x0, sx);
	assign y1 = win_hi(y0, sy);
	assign z1 = win_hi(z0, sz);

	// ---------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SW'(64);
			size_y_q <= SW'(64);
			size_z_q <= SW'(64);
			res_x_q  <= PW'(4096);
			res_y_q  <= PW'(4096);
			res_z_q  <= PW'(4096);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE_X: size_x_q <= cfg_data[SW-1:0];
				CFG_SIZE_Y: size_y_q <= cfg_data[SW-1:0];
				CFG_SIZE_Z: size_z_q <= cfg_data[SW-1:0];
				CFG_RES_X:  res_x_q  <= cfg_data;
				CFG_RES_Y:  res_y_q  <= cfg_data;
				CFG_RES_Z:  res_z_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- flag store
	assign take_item = (state_q == ST_IDLE) && item_valid;
	assign ram_we    = (state_q == ST_CLEAR) || (take_item && item.action == ACT_WRITE);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : {item.write_z, item.write_y, item.write_x};
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : item.positive_mask;
	assign ram_raddr = (state_q == ST_CREQ) ? {cz_q, cy_q, cx_q} : {z_q, y_q, x_q};

	npvs_ram #(
		.WIDTH(COMPONENTS),
		.DEPTH(MAX_DIM * MAX_DIM * MAX_DIM)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------- locate: one shared divider, axes in turn
	always_comb begin
		case (axis_q)
			2'd0:    begin div_num = pos_x_q; div_den = res_x_q; sel_size = sx; end
			2'd1:    begin div_num = pos_y_q; div_den = res_y_q; sel_size = sy; end
			default: begin div_num = pos_z_q; div_den = res_z_q; sel_size = sz; end
		endcase
	end

	npvs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go_q),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// zero resolution gives all ones, which clamps to size-1
	assign clamped = (div_quo >= PW'(sel_size)) ? IW'(sel_size - SW'(1)) : div_quo[IW-1:0];

	npvs_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (dist_go_q),
		.idx_x  (x_q),
		.idx_y  (y_q),
		.idx_z  (z_q),
		.pos_x  (pos_x_q),
		.pos_y  (pos_y_q),
		.pos_z  (pos_z_q),
		.res_x  (res_x_q),
		.res_y  (res_y_q),
		.res_z  (res_z_q),
		.done   (dist_done),
		.dist_sq(dist_sq)
	);

	// ---------------- scan order: component, z, y, x
	always_comb begin
		x_n       = x_q;
		y_n       = y_q;
		z_n       = z_q;
		comp_n    = comp_q;
		scan_last = 1'b0;
		if (({1'b0, x_q} + SW'(1)) < x1) begin
			x_n = x_q + IW'(1);
		end else begin
			x_n = x0[IW-1:0];
			if (({1'b0, y_q} + SW'(1)) < y1) begin
				y_n = y_q + IW'(1);
			end else begin
				y_n = y0[IW-1:0];
				if (({1'b0, z_q} + SW'(1)) < z1) begin
					z_n = z_q + IW'(1);
				end else begin
					z_n = z0[IW-1:0];
					if (comp_q != CMW'(COMPONENTS - 1))
						comp_n = comp_q + CMW'(1);
					else
						scan_last = 1'b1;
				end
			end
		end
	end

	assign out_load = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			axis_q         <= '0;
			div_go_q       <= 1'b0;
			dist_go_q      <= 1'b0;
			have_q         <= 1'b0;
			cpos_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			div_go_q  <= 1'b0;
			dist_go_q <= 1'b0;
			if (out_load)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (take_item && item.action == ACT_QUERY) begin
						axis_q   <= '0;
						div_go_q <= 1'b1;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (axis_q == 2'd2) begin
							state_q <= ST_CREQ;
						end else begin
							axis_q   <= axis_q + 2'd1;
							div_go_q <= 1'b1;
						end
					end
				end
				ST_CREQ: begin
					have_q  <= 1'b0;
					state_q <= ST_CCHK;
				end
				ST_CCHK: begin
					cpos_q  <= |ram_rdata;
					state_q <= (|ram_rdata) ? ST_DONE : ST_SREQ;
				end
				ST_SREQ: begin
					state_q <= ST_SCHK;
				end
				ST_SCHK: begin
					if (ram_rdata[comp_q]) begin
						dist_go_q <= 1'b1;
						state_q   <= ST_DIST;
					end else begin
						state_q <= scan_last ? ST_DONE : ST_SREQ;
					end
				end
				ST_DIST: begin
					if (dist_done) begin
						if (!have_q || dist_sq < best_q)
							have_q <= 1'b1;
						state_q <= scan_last ? ST_DONE : ST_SREQ;
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			pos_x_q <= item.pos_x;
			pos_y_q <= item.pos_y;
			pos_z_q <= item.pos_z;
		end
		if (state_q == ST_DIV && div_done) begin
			case (axis_q)
				2'd0:    cx_q <= clamped;
				2'd1:    cy_q <= clamped;
				default: cz_q <= clamped;
			endcase
		end
		if (state_q == ST_CREQ) begin
			x_q    <= x0[IW-1:0];
			y_q    <= y0[IW-1:0];
			z_q    <= z0[IW-1:0];
			comp_q <= '0;
			bx_q   <= cx_q;
			by_q   <= cy_q;
			bz_q   <= cz_q;
		end
		if ((state_q == ST_SCHK && !ram_rdata[comp_q]) || (state_q == ST_DIST && dist_done)) begin
			x_q    <= x_n;
			y_q    <= y_n;
			z_q    <= z_n;
			comp_q <= comp_n;
		end
		if (state_q == ST_DIST && dist_done && (!have_q || dist_sq < best_q)) begin
			best_q <= dist_sq;
			bx_q   <= x_q;
			by_q   <= y_q;
			bz_q   <= z_q;
		end
		if (out_load) begin
			result_q.found_x         <= bx_q;
			result_q.found_y         <= by_q;
			result_q.found_z         <= bz_q;
			result_q.center_positive <= cpos_q;
			result_q.not_found       <= !cpos_q && !have_q;
		end
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_dist_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		dist_done |-> state_q == ST_DIST)
		else $error("distance finished outside of a scan");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCHK |-> $past(state_q) == ST_SREQ)
		else $error("flag checked without a read issued the cycle before");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCHK |-> ({1'b0, x_q} >= x0 && {1'b0, x_q} < x1
			&& {1'b0, y_q} >= y0 && {1'b0, y_q} < y1
			&& {1'b0, z_q} >= z0 && {1'b0, z_q} < z1))
		else $error("scan left the search window");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.not_found && result.center_positive))
		else $error("result both center positive and not found");

endmodule

[design/npvs_ram.sv]
`timescale 1ns / 1ps

module npvs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[design/npvs_div.sv]
`timescale 1ns / 1ps

module npvs_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  logic [npvs_pkg::PW-1:0] num,
	input  logic [npvs_pkg::PW-1:0] den,
	output logic                   done,
	output logic [npvs_pkg::PW-1:0] quo
);

	import npvs_pkg::*;

	localparam int CW = $clog2(PW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] rem_q;
	logic [PW-1:0] quo_q;
	logic [PW:0]   sh;
	logic          ge;

	// restoring division, one quotient bit per cycle
	assign sh = {rem_q, quo_q[PW-1]};
	assign ge = sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(PW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? PW'(sh - {1'b0, den}) : sh[PW-1:0];
			quo_q <= {quo_q[PW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[design/npvs_dist.sv]
`timescale 1ns / 1ps

module npvs_dist (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [npvs_pkg::IW-1:0] idx_x,
	input  logic [npvs_pkg::IW-1:0] idx_y,
	input  logic [npvs_pkg::IW-1:0] idx_z,
	input  logic [npvs_pkg::PW-1:0] pos_x,
	input  logic [npvs_pkg::PW-1:0] pos_y,
	input  logic [npvs_pkg::PW-1:0] pos_z,
	input  logic [npvs_pkg::PW-1:0] res_x,
	input  logic [npvs_pkg::PW-1:0] res_y,
	input  logic [npvs_pkg::PW-1:0] res_z,
	output logic                    done,
	output logic [npvs_pkg::DW-1:0] dist_sq
);

	import npvs_pkg::*;

	localparam int BW = IW + 1 + PW;

	logic          issue_q;
	logic [1:0]    k_q;
	logic [IW-1:0] sel_i;
	logic [PW-1:0] sel_p;
	logic [PW-1:0] sel_r;

	logic          v_s1, v_s2, v_s3;
	logic          last_s1, last_s2, last_s3;
	logic [BW-1:0] a_s1, b_s1;
	logic [BW-1:0] d_s2;
	logic [2*BW-1:0] sq_s3;
	logic [DW-1:0] acc_q;
	logic          done_q;

	always_comb begin
		case (k_q)
			2'd0:    begin sel_i = idx_x; sel_p = pos_x; sel_r = res_x; end
			2'd1:    begin sel_i = idx_y; sel_p = pos_y; sel_r = res_y; end
			default: begin sel_i = idx_z; sel_p = pos_z; sel_r = res_z; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (go) begin
				issue_q <= 1'b1;
				k_q     <= '0;
			end else if (issue_q) begin
				k_q <= k_q + 2'd1;
				if (k_q == 2'd2)
					issue_q <= 1'b0;
			end
			v_s1   <= issue_q && !go;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3 && last_s3;
		end
	end

	// doubled coordinates: (2*pos - (2*i+1)*res)^2 per axis
	always_ff @(posedge clk) begin
		last_s1 <= k_q == 2'd2;
		a_s1    <= BW'({sel_p, 1'b0});
		b_s1    <= BW'({sel_i, 1'b1}) * BW'(sel_r);
		last_s2 <= last_s1;
		d_s2    <= (a_s1 >= b_s1) ? a_s1 - b_s1 : b_s1 - a_s1;
		last_s3 <= last_s2;
		sq_s3   <= (2*BW)'(d_s2) * (2*BW)'(d_s2);
		if (go)
			acc_q <= '0;
		else if (v_s3)
			acc_q <= acc_q + DW'(sq_s3);
	end

	assign done    = done_q;
	assign dist_sq = acc_q;

endmodule

[bench/npvs_checker.sv]
`timescale 1ns / 1ps

module npvs_checker
	import npvs_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_stall,
	input  item_t          item,
	input  logic           result_valid,
	input  logic           result_stall,
	input  result_t        result,
	input  logic           cfg_we,
	input  logic [CIW-1:0] cfg_index,
	input  logic [PW-1:0]  cfg_data,
	output int             fail_count,
	output int             pending
);

	localparam int RADIUS = 5;

	bit [COMPONENTS-1:0] voxel_flags [0:MAX_DIM*MAX_DIM*MAX_DIM-1];
	logic [SW-1:0] grid_x, grid_y, grid_z;
	logic [PW-1:0] step_x, step_y, step_z;
	result_t       nearest_queue [$];
	int            mismatches;

	initial begin
		foreach (voxel_flags[i])
			voxel_flags[i] = '0;
		grid_x = 64; grid_y = 64; grid_z = 64;
		step_x = 4096; step_y = 4096; step_z = 4096;
		mismatches = 0;
	end

	assign fail_count = mismatches;
	assign pending = nearest_queue.size();

	function automatic int used_size(logic [SW-1:0] s);
		if (s == 0)
			return 1;
		if (s > MAX_DIM)
			return MAX_DIM;
		return s;
	endfunction

	function automatic int cell_of(logic [PW-1:0] p, logic [PW-1:0] r, int n);
		int q;
		if (r == 0)
			return n - 1;
		q = p / r;
		return (q >= n) ? n - 1 : q;
	endfunction

	// doubled coordinates keep the half-voxel center exact
	function automatic logic [65:0] offset_sq(logic [PW-1:0] p, int i, logic [PW-1:0] r);
		logic [33:0] a, b, d;
		a = 34'(p) << 1;
		b = 34'(2 * i + 1) * 34'(r);
		d = (a >= b) ? a - b : b - a;
		return 66'(d) * 66'(d);
	endfunction

	function automatic int flag_addr(int x, int y, int z);
		return (z * MAX_DIM + y) * MAX_DIM + x;
	endfunction

	function automatic result_t nearest_voxel(item_t q);
		result_t     r;
		int          nx, ny, nz, cx, cy, cz, x0, x1, y0, y1, z0, z1;
		logic [65:0] best, dsq;
		bit          have;
		nx = used_size(grid_x); ny = used_size(grid_y); nz = used_size(grid_z);
		cx = cell_of(q.pos_x, step_x, nx);
		cy = cell_of(q.pos_y, step_y, ny);
		cz = cell_of(q.pos_z, step_z, nz);
		r = '0;
		r.found_x = cx; r.found_y = cy; r.found_z = cz;
		if (voxel_flags[flag_addr(cx, cy, cz)] != 0) begin
			r.center_positive = 1'b1;
			return r;
		end
		have = 0;
		best = '0;
		x0 = (cx < RADIUS) ? 0 : cx - RADIUS; x1 = (x0 + 2*RADIUS > nx) ? nx : x0 + 2*RADIUS;
		y0 = (cy < RADIUS) ? 0 : cy - RADIUS; y1 = (y0 + 2*RADIUS > ny) ? ny : y0 + 2*RADIUS;
		z0 = (cz < RADIUS) ? 0 : cz - RADIUS; z1 = (z0 + 2*RADIUS > nz) ? nz : z0 + 2*RADIUS;
		for (int c = 0; c < COMPONENTS; c++)
			for (int z = z0; z < z1; z++)
				for (int y = y0; y < y1; y++)
					for (int x = x0; x < x1; x++) begin
						if (!voxel_flags[flag_addr(x, y, z)][c])
							continue;
						dsq = offset_sq(q.pos_x, x, step_x) + offset_sq(q.pos_y, y, step_y)
							+ offset_sq(q.pos_z, z, step_z);
						if (!have || dsq < best) begin
							have = 1;
							best = dsq;
							r.found_x = x; r.found_y = y; r.found_z = z;
						end
					end
		r.not_found = !have;
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			// results first: a result leaving now belongs to an earlier query
			if (result_valid && !result_stall) begin
				if (nearest_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %p", result);
				end else begin
					want = nearest_queue.pop_front();
					if (result.found_x !== want.found_x || result.found_y !== want.found_y
						|| result.found_z !== want.found_z
						|| result.center_positive !== want.center_positive
						|| result.not_found !== want.not_found) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch: expected %p, got %p", want, result);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIZE_X: grid_x = cfg_data[SW-1:0];
					CFG_SIZE_Y: grid_y = cfg_data[SW-1:0];
					CFG_SIZE_Z: grid_z = cfg_data[SW-1:0];
					CFG_RES_X:  step_x = cfg_data;
					CFG_RES_Y:  step_y = cfg_data;
					CFG_RES_Z:  step_z = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				if (item.action == ACT_WRITE)
					voxel_flags[flag_addr(item.write_x, item.write_y, item.write_z)] =
						item.positive_mask;
				else
					nearest_queue.push_back(nearest_voxel(item));
			end
		end
	end

endmodule

[bench/nearest_positive_voxel_search_core_tb.sv]
`timescale 1ns / 1ps

module nearest_positive_voxel_search_core_tb;
	import npvs_pkg::*;

	localparam int STALL_LIMIT = 1200000;

	logic           clk = 0;
	logic           arst_n = 0;
	logic           item_valid = 0;
	logic           item_stall;
	item_t          item = '0;
	logic           result_valid;
	logic           result_stall = 0;
	result_t        result;
	logic           cfg_we = 0;
	logic [CIW-1:0] cfg_index = '0;
	logic [PW-1:0]  cfg_data = '0;
	int             fail_count, pending;
	int             beats_sent = 0;
	int             quiet_cycles = 0;
	bit             hold_done = 0;
	int             hold_left = 0;
	int             gx = 64, gy = 64, gz = 64;
	logic [PW-1:0]  rx = 4096, ry = 4096, rz = 4096;

	always #5 clk = ~clk;

	nearest_positive_voxel_search_core DUT (
		.clk, .arst_n, .item_valid, .item_stall, .item, .result_valid, .result_stall,
		.result, .cfg_we, .cfg_index, .cfg_data
	);

	npvs_checker u_checker (
		.clk, .arst_n, .item_valid, .item_stall, .item, .result_valid, .result_stall,
		.result, .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
	);

	function automatic bit calm();
		return beats_sent >= 350 && beats_sent < 450;
	endfunction

	// receiver: random stalls, one long hold-off to back the block up
	always @(posedge clk) begin
		if (!hold_done && beats_sent >= 150) begin
			hold_done <= 1;
			hold_left <= 4000;
			result_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_stall <= (hold_left > 1);
		end else begin
			result_stall <= !calm() && ($urandom_range(0, 99) < 24);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("nearest_positive_voxel_search_core_tb NOT OK");
			$finish;
		end
	end

	task automatic send_beat(item_t it);
		item_valid <= 1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		beats_sent++;
		if (!calm() && $urandom_range(0, 99) < 24) begin
			item_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_voxel(int x, int y, int z, bit m);
		item_t it;
		it = item_t'($urandom());
		it.action = ACT_WRITE;
		it.write_x = x; it.write_y = y; it.write_z = z;
		it.positive_mask = m;
		send_beat(it);
	endtask

	task automatic query_at(logic [PW-1:0] px, logic [PW-1:0] py, logic [PW-1:0] pz);
		item_t it;
		it = item_t'({$urandom(), $urandom(), $urandom()});
		it.action = ACT_QUERY;
		it.pos_x = px; it.pos_y = py; it.pos_z = pz;
		send_beat(it);
	endtask

	task automatic drain();
		item_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2200) @(posedge clk);
	endtask

	task automatic set_grid(int sx, int sy, int sz, logic [PW-1:0] ax, logic [PW-1:0] ay,
		logic [PW-1:0] az);
		logic [PW-1:0] vals [6];
		logic [CIW-1:0] idx [6];
		vals = '{sx, sy, sz, ax, ay, az};
		idx = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_SIZE_Z, CFG_RES_X, CFG_RES_Y, CFG_RES_Z};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 0;
		gx = (sx == 0) ? 1 : (sx > MAX_DIM) ? MAX_DIM : sx;
		gy = (sy == 0) ? 1 : (sy > MAX_DIM) ? MAX_DIM : sy;
		gz = (sz == 0) ? 1 : (sz > MAX_DIM) ? MAX_DIM : sz;
		rx = ax; ry = ay; rz = az;
	endtask

	function automatic logic [PW-1:0] point_in(int n, logic [PW-1:0] r);
		logic [31:0] p;
		if ($urandom_range(0, 4) == 0)
			return $urandom();
		p = $urandom_range(0, n - 1) * r + ((r == 0) ? 0 : $urandom_range(0, r - 1));
		return p[PW-1:0];
	endfunction

	function automatic int pick_size();
		case ($urandom_range(0, 5))
			0: return 1;
			1: return 64;
			2: return $urandom_range(0, 1) ? 0 : 127;
			3: return $urandom_range(1, 64);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	function automatic logic [PW-1:0] pick_res();
		case ($urandom_range(0, 5))
			0: return 1;
			1: return 24'hFFFFFF;
			2: return 0;
			3: return 4096;
			default: return $urandom_range(1, 24'hFFFFFF);
		endcase
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_grid(64, 64, 64, 4096, 4096, 4096);

		// directed: corners, center hit, empty window, tie on x
		write_voxel(0, 0, 0, 1);
		query_at(0, 0, 0);
		query_at(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		write_voxel(63, 63, 63, 1);
		query_at(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		query_at(24'h03F800, 24'h03F800, 24'h03F800);
		write_voxel(10, 10, 10, 1);
		write_voxel(12, 10, 10, 1);
		query_at(24'h00B800, 24'h00A800, 24'h00A800);
		write_voxel(0, 0, 0, 0);
		query_at(24'h002000, 24'h001000, 24'h000800);
		write_voxel(63, 0, 42, 1);
		query_at(24'h03D000, 24'h003000, 24'h02A000);
		drain();
		set_grid(0, 127, 1, 0, 24'hFFFFFF, 1);
		query_at(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		query_at(0, 0, 0);
		write_voxel(0, 63, 0, 1);
		query_at(24'h123456, 24'hFFFFFF, 0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 5)
				set_grid(64, 64, 64, 4096, 4096, 4096);
			else
				set_grid(pick_size(), pick_size(), pick_size(), pick_res(), pick_res(),
					pick_res());
			for (int k = 0; k < 100; k++) begin
				if ($urandom_range(0, 9) < 6) begin
					if ($urandom_range(0, 9) == 0)
						write_voxel($urandom_range(0, 63), $urandom_range(0, 63),
							$urandom_range(0, 63), $urandom_range(0, 1));
					else
						write_voxel($urandom_range(0, gx - 1), $urandom_range(0, gy - 1),
							$urandom_range(0, gz - 1), $urandom_range(0, 9) < 7);
				end else begin
					query_at(point_in(gx, rx), point_in(gy, ry), point_in(gz, rz));
				end
			end
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("nearest_positive_voxel_search_core_tb OK");
		else
			$display("nearest_positive_voxel_search_core_tb NOT OK");
		$finish;
	end

endmodule
